// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
// Used by spq_cell, spq_out_buf and stable_priority_queue; no dependencies.
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int POS_BITS      = 4;
  localparam int CNT_W         = $clog2(DEPTH + 1);

  localparam int IN_DATA_W  = 56;  // payload, priority, position, zero fill
  localparam int OUT_DATA_W = 56;  // read_payload, read_priority, count, zero fill

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_UP
  } cell_op_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [PRIORITY_BITS-1:0] priority_val;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctrl_t;

  typedef struct packed {
    status_t                  status;
    logic [PAYLOAD_BITS-1:0]  read_payload;
    logic [PRIORITY_BITS-1:0] read_priority;
    logic [CNT_W-1:0]         count;
  } result_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, loads the new entry,
// or takes a neighbor's entry. Depends on spq_pkg.
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,        // slot lies below the count
  input  logic                prev_keep,  // left neighbor holds on insert
  input  spq_pkg::entry_t     prev_entry,
  input  spq_pkg::entry_t     next_entry,
  output spq_pkg::entry_t     entry,
  output logic                keep
);

  spq_pkg::entry_t entry_next;

  // stored entries with priority >= new one stay ahead of it (FIFO ties)
  assign keep = occ && ($signed(entry.priority_val) >= $signed(ctrl.new_entry.priority_val));

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      spq_pkg::CELL_INSERT: begin
        if (!keep) begin
          entry_next = prev_keep ? ctrl.new_entry : prev_entry;
        end
      end
      spq_pkg::CELL_SHIFT_UP: begin
        entry_next = next_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- hw/rtl/spq_out_buf.sv -----
// Result register with a skid slot, so a stalled result does not block
// the input side for the first extra word. Depends on spq_pkg.
module spq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spq_pkg::result_t in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output spq_pkg::result_t out_word
);

  logic             skid_valid;
  spq_pkg::result_t skid_word;
  logic             out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : in_word;
    end else if (in_valid && !skid_valid) begin
      skid_word <= in_word;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid word without output word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

endmodule

// ----- hw/rtl/stable_priority_queue.sv -----
// Stable priority queue: a chain of DEPTH cells kept sorted by priority.
// An accepted word's result is registered into the output register, or into the skid slot while the output stalls.
// Throughput: one word per cycle while s_tready is high; every cell compares and shifts in the same cycle.
// A stalled output holds one further word in a skid slot, then s_tready drops.
// Reset (rst, synchronous) clears the count and the output buffer; cell contents
// are not cleared, as only slots below the count are ever read.
module stable_priority_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]      s_tdata,  // payload, priority_req, position
  input  logic [1:0]                         s_tuser,  // kind
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]     m_tdata,  // read_payload, read_priority, count
  output logic [1:0]                         m_tuser   // status
);

  localparam int PRI_LO = spq_pkg::PAYLOAD_BITS;
  localparam int POS_LO = PRI_LO + spq_pkg::PRIORITY_BITS;
  localparam int CNT_LO = spq_pkg::PAYLOAD_BITS + spq_pkg::PRIORITY_BITS;

  logic [spq_pkg::CNT_W-1:0]    count;
  logic [spq_pkg::CNT_W-1:0]    count_next;
  logic                         accept;
  spq_pkg::kind_t               kind;
  logic [spq_pkg::POS_BITS-1:0] position;
  logic                         is_full;
  logic                         is_empty;
  spq_pkg::cell_ctrl_t          ctrl;
  spq_pkg::result_t             result;
  spq_pkg::result_t             out_word;
  spq_pkg::entry_t              cell_entry [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]    cell_keep;
  logic [spq_pkg::DEPTH-1:0]    cell_occ;
  spq_pkg::entry_t              rd_entry;

  assign kind     = spq_pkg::kind_t'(s_tuser);
  assign position = s_tdata[POS_LO +: spq_pkg::POS_BITS];
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign is_empty = (count == '0);

  // read mux over the chain
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      if ({{(32 - spq_pkg::POS_BITS){1'b0}}, position} == 32'(i)) begin
        rd_entry = cell_entry[i];
      end
    end
  end

  always_comb begin
    ctrl.new_entry.payload      = s_tdata[spq_pkg::PAYLOAD_BITS-1:0];
    ctrl.new_entry.priority_val = s_tdata[PRI_LO +: spq_pkg::PRIORITY_BITS];
    ctrl.op              = spq_pkg::CELL_HOLD;
    count_next           = count;
    result.status        = spq_pkg::ST_OK;
    result.read_payload  = '0;
    result.read_priority = '0;
    case (kind)
      spq_pkg::KIND_INSERT: begin
        if (is_full) begin
          result.status = spq_pkg::ST_FULL;
        end else begin
          ctrl.op    = accept ? spq_pkg::CELL_INSERT : spq_pkg::CELL_HOLD;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::KIND_REMOVE: begin
        if (is_empty) begin
          result.status = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.op    = accept ? spq_pkg::CELL_SHIFT_UP : spq_pkg::CELL_HOLD;
          count_next = count - 1'b1;
        end
      end
      spq_pkg::KIND_READ: begin
        if (is_empty) begin
          result.status = spq_pkg::ST_EMPTY;
        end else if ({{(spq_pkg::CNT_W - spq_pkg::POS_BITS){1'b0}}, position} >= count
                     || 32'(position) >= 32'(spq_pkg::DEPTH)) begin
          result.status = spq_pkg::ST_RANGE;
        end else begin
          result.read_payload  = rd_entry.payload;
          result.read_priority = rd_entry.priority_val;
        end
      end
      default: begin
        result.status = spq_pkg::ST_OK;
      end
    endcase
    result.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == spq_pkg::DEPTH - 1) ? g : g + 1;

    assign cell_occ[g] = (32'(count) > 32'(g));

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (cell_occ[g]),
      .prev_keep  ((g == 0) ? 1'b1 : cell_keep[PREV]),
      .prev_entry (cell_entry[PREV]),
      .next_entry (cell_entry[NEXT]),
      .entry      (cell_entry[g]),
      .keep       (cell_keep[g])
    );
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_tready),
    .in_word   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tuser = out_word.status;
  assign m_tdata = {{(spq_pkg::OUT_DATA_W - CNT_LO - spq_pkg::CNT_W){1'b0}},
                    out_word.count, out_word.read_priority, out_word.read_payload};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(spq_pkg::DEPTH)) else $error("count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && kind == spq_pkg::KIND_INSERT && result.status == spq_pkg::ST_OK
    |=> count == $past(count) + 1'b1) else $error("insert did not grow count");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (rst)
    accept && result.status == spq_pkg::ST_FULL |-> is_full && kind == spq_pkg::KIND_INSERT)
    else $error("full status on a queue with room");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    cell_occ[1] |-> $signed(cell_entry[0].priority_val) >= $signed(cell_entry[1].priority_val))
    else $error("head out of order");

endmodule
